>>> hdl/magnetometer_poll_sequencer_unit_assert.svh
// assertion macros for the magnetometer poll sequencer
`ifndef MAGNETOMETER_POLL_SEQUENCER_UNIT_ASSERT_SVH
`define MAGNETOMETER_POLL_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define MPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mps assertion failed");

// next-cycle implication, disabled while reset is asserted
`define MPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mps assertion failed");

`endif

>>> hdl/mps_pkg.sv
// shared types, codes and helpers of the magnetometer poll sequencer
`default_nettype none
package mps_pkg;

  localparam int unsigned AxisW     = 18;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CountW    = 16;
  localparam int unsigned TimeoutW  = 8;
  localparam int unsigned InDataW   = 104;
  localparam int unsigned OutDataW  = 112;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned StatusDoneBit = 0;
  localparam logic [CountW-1:0]   CountMax     = '1;
  localparam logic [TimeoutW-1:0] TimeoutReset = 8'd15;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_BUSY      = 2'd1,
    RES_BUS_ERROR = 2'd2,
    RES_TIMEOUT   = 2'd3
  } result_code_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_SENSOR_READY = 2'd0,
    CFG_TIMEOUT_MS   = 2'd1
  } cfg_index_e;

  typedef struct packed {
    logic                sensor_ready;
    logic [TimeoutW-1:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             trigger_ok;
    logic             status_ok;
    logic [7:0]       status_byte;
    logic             data_ok;
    logic [7:0]       x_high;
    logic [7:0]       x_low;
    logic [7:0]       y_high;
    logic [7:0]       y_low;
    logic [7:0]       z_high;
    logic [7:0]       z_low;
    logic [7:0]       axis_lsbs;
  } item_t;

  typedef struct packed {
    logic                    pending;
    logic [TimeW-1:0]        start_time;
    logic                    online;
    logic [CountW-1:0]       failures;
    logic signed [AxisW-1:0] axis_x;
    logic signed [AxisW-1:0] axis_y;
    logic signed [AxisW-1:0] axis_z;
    logic [TimeW-1:0]        sample_time;
  } mps_state_t;

  typedef struct packed {
    result_code_e            code;
    logic                    online;
    logic [CountW-1:0]       fail_count;
    logic signed [AxisW-1:0] field_x;
    logic signed [AxisW-1:0] field_y;
    logic signed [AxisW-1:0] field_z;
    logic [TimeW-1:0]        last_update_ms;
  } result_t;

  // raw 18-bit value minus the mid-scale centre: flipping the top bit does it
  function automatic logic signed [AxisW-1:0] assemble_axis(
    input logic [7:0] hi,
    input logic [7:0] lo,
    input logic [1:0] two
  );
    logic [AxisW-1:0] raw;
    raw = {hi, lo, two};
    return $signed({~raw[AxisW-1], raw[AxisW-2:0]});
  endfunction

endpackage
`default_nettype wire

>>> hdl/magnetometer_poll_sequencer_unit.sv
// top level of the magnetometer poll sequencer
// Each input beat is one poll of the sensor: the time and the outcome of the
// trigger write, status read and data read. The block answers every poll with
// exactly one result beat (code, online flag, error count, latest field values
// and sample time). It takes one beat per clock while the output side accepts
// results; a beat lands in an input register, the step logic forms the state
// update and result from it, and the result is held in an output register
// until taken. The step logic updates the state combinationally, which sets
// the one-beat-per-cycle rate. Configuration writes are taken at any edge
// with cfg_we_i high and should only be made while the block is idle;
// indexes beyond the two registers are ignored.
`default_nettype none
`include "magnetometer_poll_sequencer_unit_assert.svh"
module magnetometer_poll_sequencer_unit
  import mps_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // configuration write port
  input  wire                 cfg_we_i,
  input  wire [CfgIndexW-1:0] cfg_index_i,
  input  wire [CfgDataW-1:0]  cfg_wdata_i,
  // poll beats in
  input  wire                 s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // now_ms, trigger_ok, status_ok, status_byte, data_ok, x_high, x_low,
  // y_high, y_low, z_high, z_low, axis low bits, zero fill
  input  wire [InDataW-1:0]   s_axis_tdata_i,
  // result beats out
  output logic                m_axis_tvalid_o,
  input  wire                 m_axis_tready_i,
  // result_code, online, fail count, field_x, field_y, field_z,
  // last_update_ms, zero fill
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  cfg_t       cfg_q;
  item_t      in_item_q;
  logic       in_valid_q;
  mps_state_t state_q, state_d;
  result_t    res_d, out_q;
  logic       out_valid_q;
  logic       advance;
  item_t      in_item;

  // unpack the input beat
  assign in_item.now_ms      = s_axis_tdata_i[31:0];
  assign in_item.trigger_ok  = s_axis_tdata_i[32];
  assign in_item.status_ok   = s_axis_tdata_i[33];
  assign in_item.status_byte = s_axis_tdata_i[41:34];
  assign in_item.data_ok     = s_axis_tdata_i[42];
  assign in_item.x_high      = s_axis_tdata_i[50:43];
  assign in_item.x_low       = s_axis_tdata_i[58:51];
  assign in_item.y_high      = s_axis_tdata_i[66:59];
  assign in_item.y_low       = s_axis_tdata_i[74:67];
  assign in_item.z_high      = s_axis_tdata_i[82:75];
  assign in_item.z_low       = s_axis_tdata_i[90:83];
  assign in_item.axis_lsbs   = s_axis_tdata_i[98:91];

  // handshake: the staged beat moves on when the output register frees up
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_ready <= 1'b0;
      cfg_q.timeout_ms   <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SENSOR_READY: cfg_q.sensor_ready <= cfg_wdata_i[0];
        CFG_TIMEOUT_MS:   cfg_q.timeout_ms   <= cfg_wdata_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_item_q <= in_item;
    end
  end

  // step logic
  mps_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.pending     <= 1'b0;
      state_q.start_time  <= '0;
      state_q.online      <= 1'b1;
      state_q.failures    <= '0;
      state_q.axis_x      <= '0;
      state_q.axis_y      <= '0;
      state_q.axis_z      <= '0;
      state_q.sample_time <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  // pack the result beat
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_q.last_update_ms, out_q.field_z, out_q.field_y,
                            out_q.field_x, out_q.fail_count, out_q.online, out_q.code};

  // checks
  `MPS_ASSERT_NEXT(a_advance_fills_out, clk_i, rst_ni, advance, out_valid_q)
  `MPS_ASSERT_NEXT(a_count_never_drops, clk_i, rst_ni, 1'b1,
                   state_q.failures >= $past(state_q.failures))
  `MPS_ASSERT_NOW(a_ok_means_online, clk_i, rst_ni,
                  out_valid_q && (out_q.code == RES_OK), out_q.online)
  `MPS_ASSERT_NEXT(a_timeout_clears, clk_i, rst_ni,
                   advance && (res_d.code == RES_TIMEOUT),
                   !state_q.pending && !state_q.online)
  `MPS_ASSERT_NOW(a_empty_stage_ready, clk_i, rst_ni, !in_valid_q, s_axis_tready_o)

endmodule
`default_nettype wire

>>> hdl/mps_step.sv
// one poll step: next sequencer state and the result beat
`default_nettype none
module mps_step
  import mps_pkg::*;
(
  input  wire cfg_t       cfg_i,
  input  wire mps_state_t state_i,
  input  wire item_t      item_i,
  output mps_state_t      state_o,
  output result_t         result_o
);

  logic                fail;
  result_code_e        code;
  logic [TimeW-1:0]    elapsed;
  logic                late;

  // wrapping elapsed time against the limit
  assign elapsed = item_i.now_ms - state_i.start_time;
  assign late    = elapsed > {{(TimeW-TimeoutW){1'b0}}, cfg_i.timeout_ms};

  // decision tree of one poll
  always_comb begin
    state_o = state_i;
    fail    = 1'b0;
    code    = RES_BUSY;
    if (!cfg_i.sensor_ready) begin
      state_o.online = 1'b0;
      code           = RES_BUS_ERROR;
    end else if (!state_i.pending) begin
      if (!item_i.trigger_ok) begin
        fail = 1'b1;
        code = RES_BUS_ERROR;
      end else begin
        state_o.pending    = 1'b1;
        state_o.start_time = item_i.now_ms;
        code               = RES_BUSY;
      end
    end else if (!item_i.status_ok) begin
      state_o.pending = 1'b0;
      fail            = 1'b1;
      code            = RES_BUS_ERROR;
    end else if (!item_i.status_byte[StatusDoneBit]) begin
      if (late) begin
        state_o.pending = 1'b0;
        fail            = 1'b1;
        code            = RES_TIMEOUT;
      end else begin
        code = RES_BUSY;
      end
    end else if (!item_i.data_ok) begin
      state_o.pending = 1'b0;
      fail            = 1'b1;
      code            = RES_BUS_ERROR;
    end else begin
      state_o.axis_x      = assemble_axis(item_i.x_high, item_i.x_low,
                                          item_i.axis_lsbs[7:6]);
      state_o.axis_y      = assemble_axis(item_i.y_high, item_i.y_low,
                                          item_i.axis_lsbs[5:4]);
      state_o.axis_z      = assemble_axis(item_i.z_high, item_i.z_low,
                                          item_i.axis_lsbs[3:2]);
      state_o.sample_time = item_i.now_ms;
      state_o.online      = 1'b1;
      state_o.pending     = 1'b0;
      code                = RES_OK;
    end
    // failure bookkeeping with a saturating count
    if (fail) begin
      state_o.online = 1'b0;
      if (state_i.failures != CountMax) begin
        state_o.failures = state_i.failures + 1'b1;
      end
    end
  end

  // result fields reflect the state after this poll
  always_comb begin
    result_o.code           = code;
    result_o.online         = state_o.online;
    result_o.fail_count     = state_o.failures;
    result_o.field_x        = state_o.axis_x;
    result_o.field_y        = state_o.axis_y;
    result_o.field_z        = state_o.axis_z;
    result_o.last_update_ms = state_o.sample_time;
  end

endmodule
`default_nettype wire
